// ===== rtl/core/sabt_pkg.sv =====
// shared types and constants for the selective ack bitmap tracker
package sabt_pkg;

  localparam int TRACK_SIZE  = 64;
  localparam int WINDOW_BITS = 32;
  localparam int TRK_IDX_W   = $clog2(TRACK_SIZE);

  localparam int SEQ_W      = 16;
  localparam int TIME_W     = 64;
  localparam int ACK_BITS_W = 32;
  localparam int CNT_W      = 16;
  localparam int THR_W      = 8;
  localparam int LIM_W      = 32;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [ACT_W-1:0] ACT_RX    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CHECK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 8'd1;

  localparam logic [THR_W-1:0] THR_RESET = 8'd2;
  localparam logic [LIM_W-1:0] LIM_RESET = 32'd10000000;

  typedef logic [TRACK_SIZE-1:0] map_t;

  // newest seq and window after the bitmap update
  typedef struct packed {
    logic [SEQ_W-1:0]      newest;
    logic [ACK_BITS_W-1:0] window;
  } map_res_t;

  typedef struct packed {
    logic [SEQ_W-1:0]      ack_seq;
    logic [ACK_BITS_W-1:0] ack_bits;
    logic                  ack_pending;
    logic                  send_now;
    logic [CNT_W-1:0]      pending_packets;
  } result_t;

endpackage

// ===== rtl/core/sabt_map.sv =====
// received bitmap and newest sequence number, updated per packet
module sabt_map (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [sabt_pkg::ACT_W-1:0]  action,
  input  logic [sabt_pkg::SEQ_W-1:0]  seq_num,
  output sabt_pkg::map_res_t          map_res
);

  logic [sabt_pkg::SEQ_W-1:0] newest_r, newest_nxt;
  sabt_pkg::map_t             map_r, map_nxt;
  logic [sabt_pkg::SEQ_W-1:0] fwd;
  logic [sabt_pkg::SEQ_W-1:0] back;
  logic                       first_pkt;
  logic                       newer;

  always_comb begin
    fwd       = seq_num - newest_r;
    back      = newest_r - seq_num;
    first_pkt = (map_r == '0) && (newest_r == '0);
    // serial order: forward distance 1..32767 is newer
    newer     = (fwd != '0) && !fwd[sabt_pkg::SEQ_W-1];
    newest_nxt = newest_r;
    map_nxt    = map_r;
    if (action == sabt_pkg::ACT_RX) begin
      if (first_pkt) begin
        newest_nxt = seq_num;
        map_nxt    = sabt_pkg::map_t'(1);
      end else if (newer) begin
        newest_nxt = seq_num;
        if (fwd >= sabt_pkg::SEQ_W'(sabt_pkg::TRACK_SIZE)) begin
          map_nxt = '0;
        end else begin
          map_nxt = map_r << fwd[sabt_pkg::TRK_IDX_W-1:0];
        end
        map_nxt[0] = 1'b1;
      end else if (back < sabt_pkg::SEQ_W'(sabt_pkg::TRACK_SIZE)) begin
        map_nxt[back[sabt_pkg::TRK_IDX_W-1:0]] = 1'b1;
      end
    end
  end

  // window bit i-1 holds map bit i
  always_comb begin
    map_res.newest = newest_nxt;
    map_res.window = '0;
    for (int i = 1; i <= sabt_pkg::WINDOW_BITS; i++) begin
      if (i <= sabt_pkg::ACK_BITS_W && i < sabt_pkg::TRACK_SIZE) begin
        map_res.window[i-1] = map_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      map_r    <= '0;
    end else if (step_en) begin
      newest_r <= newest_nxt;
      map_r    <= map_nxt;
    end
  end

endmodule

// ===== rtl/core/sabt_pend.sv =====
// pending ack bookkeeping, config registers and the send decision
module sabt_pend (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  logic [sabt_pkg::ACT_W-1:0]      action,
  input  logic [sabt_pkg::TIME_W-1:0]     now_time,
  input  sabt_pkg::map_res_t              map_res,
  input  logic                            cfg_we,
  input  logic [sabt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sabt_pkg::CFG_DATA_W-1:0] cfg_data,
  output sabt_pkg::result_t               result
);

  logic                              pend_r, pend_nxt;
  logic [sabt_pkg::TIME_W-1:0]       first_r, first_nxt;
  logic [sabt_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [sabt_pkg::SEQ_W-1:0]        hseq_r, hseq_nxt;
  logic [sabt_pkg::ACK_BITS_W-1:0]   hbits_r, hbits_nxt;
  logic [sabt_pkg::THR_W-1:0]        thr_r;
  logic [sabt_pkg::LIM_W-1:0]        lim_r;
  logic [sabt_pkg::TIME_W-1:0]       elapsed;

  always_comb begin
    pend_nxt  = pend_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    hseq_nxt  = hseq_r;
    hbits_nxt = hbits_r;
    if (action == sabt_pkg::ACT_RX) begin
      if (!pend_r) begin
        pend_nxt  = 1'b1;
        first_nxt = now_time;
      end
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      hseq_nxt  = map_res.newest;
      hbits_nxt = map_res.window;
    end else if (action == sabt_pkg::ACT_CLEAR) begin
      pend_nxt  = 1'b0;
      first_nxt = '0;
      cnt_nxt   = '0;
      hseq_nxt  = '0;
      hbits_nxt = '0;
    end
    elapsed = now_time - first_nxt;
    result.ack_seq         = hseq_nxt;
    result.ack_bits        = hbits_nxt;
    result.ack_pending     = pend_nxt;
    result.pending_packets = cnt_nxt;
    result.send_now        = pend_nxt &&
                             ((cnt_nxt >= sabt_pkg::CNT_W'(thr_r)) ||
                              (elapsed >= sabt_pkg::TIME_W'(lim_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      first_r <= '0;
      cnt_r   <= '0;
      hseq_r  <= '0;
      hbits_r <= '0;
    end else if (step_en) begin
      pend_r  <= pend_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
      hseq_r  <= hseq_nxt;
      hbits_r <= hbits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= sabt_pkg::THR_RESET;
      lim_r <= sabt_pkg::LIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sabt_pkg::CFG_THRESHOLD) begin
        thr_r <= cfg_data[sabt_pkg::THR_W-1:0];
      end else if (cfg_index == sabt_pkg::CFG_DELAY) begin
        lim_r <= cfg_data[sabt_pkg::LIM_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/selective_ack_bitmap_tracker.sv =====
// selective ack bitmap tracker: the receive side of a reliable channel
//
// in_*  : one request per cycle when in_ready; action 0 records a received
//         seq_num, 1 clears the pending ack once sent, 2 only checks time.
// out_* : exactly one result per request: the seq to ack, a 32 bit window of
//         earlier seqs, pending flag, count, and send_now when the count
//         threshold is reached or the oldest pending packet waited too long.
// cfg_* : index 0 count threshold, index 1 delay limit in ns; always ready,
//         other indexes are ignored. write only while no request is in flight.
// throughput: one request per cycle while out_ready keeps the result register
// free; the state update runs between the input register and the result
// register.
// a stalled out_ready holds the result register; the input register still
// takes one more request, and in_ready drops only when both are full.
// reset (rst_n low, synchronous) empties both registers, clears the bitmap and
// pending state and loads the register defaults (threshold 2, limit 10 ms).
module selective_ack_bitmap_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sabt_pkg::ACT_W-1:0]      in_action,
  input  logic [sabt_pkg::SEQ_W-1:0]      in_seq_num,
  input  logic [sabt_pkg::TIME_W-1:0]     in_now_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sabt_pkg::SEQ_W-1:0]      out_ack_seq,
  output logic [sabt_pkg::ACK_BITS_W-1:0] out_ack_bits,
  output logic                            out_ack_pending,
  output logic                            out_send_now,
  output logic [sabt_pkg::CNT_W-1:0]      out_pending_packets,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sabt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sabt_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                          s1_valid_r;
  logic [sabt_pkg::ACT_W-1:0]    s1_action_r;
  logic [sabt_pkg::SEQ_W-1:0]    s1_seq_r;
  logic [sabt_pkg::TIME_W-1:0]   s1_now_r;
  logic                          out_valid_r;
  sabt_pkg::result_t             res_r;
  sabt_pkg::result_t             res_nxt;
  sabt_pkg::map_res_t            map_res;
  logic                          out_free;
  logic                          step_en;
  logic                          in_acc;

  assign out_free  = !out_valid_r || out_ready;
  assign step_en   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_seq_r    <= in_seq_num;
      s1_now_r    <= in_now_time;
    end
  end

  sabt_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .action  (s1_action_r),
    .seq_num (s1_seq_r),
    .map_res (map_res)
  );

  sabt_pend u_pend (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .action    (s1_action_r),
    .now_time  (s1_now_r),
    .map_res   (map_res),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ack_seq         = res_r.ack_seq;
  assign out_ack_bits        = res_r.ack_bits;
  assign out_ack_pending     = res_r.ack_pending;
  assign out_send_now        = res_r.send_now;
  assign out_pending_packets = res_r.pending_packets;

endmodule

// ===== rtl/core/sabt_checker.sv =====
// port level checks for the selective ack bitmap tracker, bound to the top level
module sabt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sabt_pkg::SEQ_W-1:0]      out_ack_seq,
  input logic [sabt_pkg::ACK_BITS_W-1:0] out_ack_bits,
  input logic                            out_ack_pending,
  input logic                            out_send_now,
  input logic [sabt_pkg::CNT_W-1:0]      out_pending_packets
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ack_seq) &&
      $stable(out_ack_bits) && $stable(out_pending_packets))
    else $error("result changed while stalled");

  a_send_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_now |-> out_ack_pending)
    else $error("send_now without a pending ack");

  // nothing pending means the held ack was cleared or never set
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ack_pending |->
      out_pending_packets == '0 && out_ack_seq == '0 && out_ack_bits == '0)
    else $error("held ack state without a pending ack");

  a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_pending |-> out_pending_packets != '0)
    else $error("pending ack with zero count");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind selective_ack_bitmap_tracker sabt_checker u_sabt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_ack_seq         (out_ack_seq),
  .out_ack_bits        (out_ack_bits),
  .out_ack_pending     (out_ack_pending),
  .out_send_now        (out_send_now),
  .out_pending_packets (out_pending_packets)
);
